### rtl/core/cpms_pkg.sv
package cpms_pkg;

   // Fixed-point format and histogram geometry
   localparam int FRAC_BITS = 16;
   localparam int POS_W     = FRAC_BITS + 1;
   localparam int ONE_FX    = 1 << FRAC_BITS;
   localparam int NUM_BINS  = 128;
   localparam int BIN_W     = $clog2(NUM_BINS);
   localparam int COUNT_W   = 32;

   // Random draws are 16-bit fractions of one
   localparam int DRAW_W   = 16;
   localparam int DRAW_ONE = 1 << DRAW_W;

   // Serial multiplier: one multiplier bit per cycle
   localparam int MUL_W     = POS_W;
   localparam int PROD_W    = 2 * MUL_W;
   localparam int MUL_CNT_W = $clog2(MUL_W);

   // Serial divider: one quotient bit per cycle
   localparam int DIV_NUM_W = POS_W + FRAC_BITS;
   localparam int DIV_DEN_W = POS_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

   // Signed working width of a trial position
   localparam int NW_W = POS_W + 2;

   // Histogram bin arithmetic
   localparam int BIN_PROD_W = POS_W + BIN_W + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTRAINT_PRODUCT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE          = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_INTERVAL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP_STEPS       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_POSITION   = 3'd4;

   // Register reset values
   localparam logic [POS_W-1:0] RST_CONSTRAINT_PRODUCT = 17'd3277;
   localparam logic [POS_W-1:0] RST_STEP_SIZE          = 17'd3277;
   localparam logic [15:0]      RST_SAMPLE_INTERVAL    = 16'd200;
   localparam logic [19:0]      RST_WARMUP_STEPS       = 20'd200;
   localparam logic [POS_W-1:0] RST_INITIAL_POSITION   = 17'd14654;

   // Command codes
   localparam logic [1:0] CMD_STEP    = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic        pick;
      logic [15:0] disp_draw;
      logic [15:0] accept_draw;
      logic [6:0]  read_bin;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [16:0] position_first;
      logic [16:0] position_second;
      logic        sampled;
      logic [6:0]  sampled_bin;
      logic [31:0] bin_count;
      logic [31:0] total_samples;
      logic [31:0] accepted_total;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_DISP,
      ST_QUOT_GO,
      ST_QUOT,
      ST_BIN,
      ST_HREAD,
      ST_RDWAIT,
      ST_REPLY
   } state_type;

endpackage

### rtl/core/constrained_pair_metropolis_sampler_top.sv
// Metropolis sampler for two positions in [0,1] (unsigned Q1.16) whose product
// is held at constraint_product. A command beat is taken when start is high and
// busy is low; each command returns exactly one result beat on rsp_data, marked
// by rsp_valid for a single cycle, and the receiver cannot stall it. A step
// runs a bit-serial multiply for the displacement, then a bit-serial divide for
// the partner position (the acceptance multiply and the step-index modulo run
// beside them), and a read-modify-write of the histogram bin when it samples.
// busy falls in the cycle the result appears, so the next command can be taken
// there. The histogram lives in a 128 x 32 RAM with a valid bit per bin, so
// reset and restart clear it at once with no clearing pass. Configuration
// writes are always ready and must only be made while no command is in flight.
module constrained_pair_metropolis_sampler_top import cpms_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  req_type               req_data,
   output logic                  rsp_valid,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   // Control and architectural state
   state_type          state_ff, state_in;
   logic [POS_W-1:0]   cp_ff, cp_in;
   logic [POS_W-1:0]   step_ff, step_in;
   logic [15:0]        interval_ff, interval_in;
   logic [19:0]        warmup_ff, warmup_in;
   logic [POS_W-1:0]   init_ff, init_in;
   logic [POS_W-1:0]   pos_a_ff, pos_a_in;
   logic [POS_W-1:0]   pos_b_ff, pos_b_in;
   logic [COUNT_W-1:0] step_cnt_ff, step_cnt_in;
   logic [COUNT_W-1:0] samp_tot_ff, samp_tot_in;
   logic [COUNT_W-1:0] acc_tot_ff, acc_tot_in;
   logic [NUM_BINS-1:0] hvalid_ff, hvalid_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Per-command working registers
   req_type            req_ff, req_in;
   logic [POS_W-1:0]   npos_ff, npos_in;
   logic               move_ok_ff, move_ok_in;
   logic               acc_ff, acc_in;
   logic               smp_ff, smp_in;
   logic [BIN_W-1:0]   sbin_ff, sbin_in;
   logic [COUNT_W-1:0] bcount_ff, bcount_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   // Arithmetic unit hookup
   logic                 mul_start, mul_busy;
   logic [MUL_W-1:0]     mul_a, mul_b;
   logic [PROD_W-1:0]    mul_prod;
   logic                 qdiv_start, qdiv_busy;
   logic [DIV_NUM_W-1:0] qdiv_quot;
   logic                 mdiv_start, mdiv_busy;
   logic [DIV_DEN_W-1:0] mdiv_rem;

   // Histogram RAM hookup
   logic               ram_wr_en;
   logic [BIN_W-1:0]   ram_wr_addr;
   logic [COUNT_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [BIN_W-1:0]   ram_rd_addr;
   logic [COUNT_W-1:0] ram_rd_data;

   // Datapath helpers
   logic                  disp_neg;
   logic [MUL_W-1:0]      disp_mag;
   logic [POS_W-1:0]      pick_pos;
   logic [PROD_W:0]       prod_round;
   logic [NW_W-1:0]       dmag;
   logic [NW_W-1:0]       nw;
   logic                  nw_ok;
   logic                  quot_ok;
   logic                  draw_wins;
   logic                  move_acc;
   logic [15:0]           interval_eff;
   logic [BIN_PROD_W-1:0] bin_prod;
   logic [BIN_PROD_W-1:0] bin_raw;
   logic [BIN_W-1:0]      bin_calc;
   logic                  rb_ok;
   logic [BIN_W-1:0]      rb_idx;
   logic [COUNT_W-1:0]    hist_count;

   // Displacement magnitude |2u - 1| in draw units, sign kept apart
   assign disp_neg = ~req_ff.disp_draw[DRAW_W-1];
   assign disp_mag = disp_neg ? (MUL_W'(DRAW_ONE) - {req_ff.disp_draw, 1'b0})
                              : {1'b0, req_ff.disp_draw[DRAW_W-2:0], 1'b0};

   // Multiplier shared: displacement first, then the acceptance product
   assign mul_a = (state_ff == ST_QUOT_GO) ? npos_ff : step_ff;
   assign mul_b = (state_ff == ST_QUOT_GO) ? MUL_W'(req_ff.accept_draw) : disp_mag;

   assign pick_pos = req_ff.pick ? pos_b_ff : pos_a_ff;

   // Trial position; negative displacements round away from zero
   assign prod_round = {1'b0, mul_prod} + (disp_neg ? (PROD_W + 1)'(DRAW_ONE - 1) : '0);
   assign dmag       = NW_W'(prod_round >> DRAW_W);
   assign nw         = disp_neg ? ({2'b00, pick_pos} - dmag) : ({2'b00, pick_pos} + dmag);
   assign nw_ok      = !nw[NW_W-1] && (nw != '0) && (nw <= NW_W'(ONE_FX));

   // Acceptance: partner in range and r * new < old * 2^16
   assign quot_ok   = (qdiv_quot <= DIV_NUM_W'(ONE_FX));
   assign draw_wins = (mul_prod < PROD_W'({pick_pos, {DRAW_W{1'b0}}}));
   assign move_acc  = move_ok_ff && quot_ok && draw_wins;

   assign interval_eff = (interval_ff == '0) ? 16'd1 : interval_ff;

   // Bin of the picked position, top bin saturated
   assign bin_prod = BIN_PROD_W'(pick_pos) * BIN_PROD_W'(NUM_BINS);
   assign bin_raw  = bin_prod >> FRAC_BITS;
   assign bin_calc = (bin_raw > BIN_PROD_W'(NUM_BINS - 1)) ? BIN_W'(NUM_BINS - 1)
                                                           : BIN_W'(bin_raw);

   assign rb_ok      = (int'(req_ff.read_bin) < NUM_BINS);
   assign rb_idx     = BIN_W'(req_ff.read_bin);
   assign hist_count = hvalid_ff[sbin_ff] ? ram_rd_data : '0;

   // Next state, configuration writes and command sequencing
   always_comb begin
      state_in     = state_ff;
      cp_in        = cp_ff;
      step_in      = step_ff;
      interval_in  = interval_ff;
      warmup_in    = warmup_ff;
      init_in      = init_ff;
      pos_a_in     = pos_a_ff;
      pos_b_in     = pos_b_ff;
      step_cnt_in  = step_cnt_ff;
      samp_tot_in  = samp_tot_ff;
      acc_tot_in   = acc_tot_ff;
      hvalid_in    = hvalid_ff;
      rsp_valid_in = 1'b0;
      req_in       = req_ff;
      npos_in      = npos_ff;
      move_ok_in   = move_ok_ff;
      acc_in       = acc_ff;
      smp_in       = smp_ff;
      sbin_in      = sbin_ff;
      bcount_in    = bcount_ff;
      rsp_data_in  = rsp_data_ff;
      mul_start    = 1'b0;
      qdiv_start   = 1'b0;
      mdiv_start   = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = sbin_ff;
      ram_wr_data  = hist_count + 1'b1;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = bin_calc;

      // register writes: the user must make them only while idle; the block does not enforce it
      if (csr_valid) begin
         unique case (csr_index)
            CSR_CONSTRAINT_PRODUCT: cp_in       = csr_wdata[POS_W-1:0];
            CSR_STEP_SIZE:          step_in     = csr_wdata[POS_W-1:0];
            CSR_SAMPLE_INTERVAL:    interval_in = csr_wdata[15:0];
            CSR_WARMUP_STEPS:       warmup_in   = csr_wdata[19:0];
            CSR_INITIAL_POSITION:   init_in     = csr_wdata[POS_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_LAUNCH;
            end
         end

         ST_LAUNCH: begin
            acc_in    = 1'b0;
            smp_in    = 1'b0;
            sbin_in   = '0;
            bcount_in = '0;
            unique case (req_ff.command)
               CMD_STEP: begin
                  mul_start  = 1'b1;
                  mdiv_start = 1'b1;
                  state_in   = ST_DISP;
               end
               CMD_READ: begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = rb_idx;
                  state_in    = ST_RDWAIT;
               end
               CMD_RESTART: begin
                  pos_a_in    = init_ff;
                  pos_b_in    = init_ff;
                  step_cnt_in = '0;
                  samp_tot_in = '0;
                  acc_tot_in  = '0;
                  hvalid_in   = '0;
                  state_in    = ST_REPLY;
               end
               default: state_in = ST_REPLY;
            endcase
         end

         // displacement product ready: form and range-check the trial position
         ST_DISP: begin
            if (!mul_busy) begin
               npos_in    = nw[POS_W-1:0];
               move_ok_in = nw_ok;
               state_in   = ST_QUOT_GO;
            end
         end

         ST_QUOT_GO: begin
            mul_start  = 1'b1;
            qdiv_start = 1'b1;
            state_in   = ST_QUOT;
         end

         // partner position, acceptance product and step modulo ready: decide the move and the sample
         ST_QUOT: begin
            if (!qdiv_busy && !mul_busy && !mdiv_busy) begin
               acc_in = move_acc;
               if (move_acc) begin
                  if (req_ff.pick) begin
                     pos_b_in = npos_ff;
                     pos_a_in = qdiv_quot[POS_W-1:0];
                  end else begin
                     pos_a_in = npos_ff;
                     pos_b_in = qdiv_quot[POS_W-1:0];
                  end
                  acc_tot_in = acc_tot_ff + 1'b1;
               end
               smp_in   = (mdiv_rem == '0) && (step_cnt_ff > COUNT_W'(warmup_ff));
               state_in = ST_BIN;
            end
         end

         ST_BIN: begin
            step_cnt_in = step_cnt_ff + 1'b1;
            if (smp_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = bin_calc;
               sbin_in     = bin_calc;
               samp_tot_in = samp_tot_ff + 1'b1;
               state_in    = ST_HREAD;
            end else begin
               state_in = ST_REPLY;
            end
         end

         // read-modify-write of the sampled bin
         ST_HREAD: begin
            ram_wr_en          = 1'b1;
            hvalid_in[sbin_ff] = 1'b1;
            state_in           = ST_REPLY;
         end

         ST_RDWAIT: begin
            bcount_in = (rb_ok && hvalid_ff[rb_idx]) ? ram_rd_data : '0;
            state_in  = ST_REPLY;
         end

         ST_REPLY: begin
            rsp_valid_in                = 1'b1;
            rsp_data_in.accepted        = acc_ff;
            rsp_data_in.position_first  = pos_a_ff;
            rsp_data_in.position_second = pos_b_ff;
            rsp_data_in.sampled         = smp_ff;
            rsp_data_in.sampled_bin     = 7'(sbin_ff);
            rsp_data_in.bin_count       = bcount_ff;
            rsp_data_in.total_samples   = samp_tot_ff;
            rsp_data_in.accepted_total  = acc_tot_ff;
            state_in                    = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cp_ff        <= RST_CONSTRAINT_PRODUCT;
         step_ff      <= RST_STEP_SIZE;
         interval_ff  <= RST_SAMPLE_INTERVAL;
         warmup_ff    <= RST_WARMUP_STEPS;
         init_ff      <= RST_INITIAL_POSITION;
         pos_a_ff     <= RST_INITIAL_POSITION;
         pos_b_ff     <= RST_INITIAL_POSITION;
         step_cnt_ff  <= '0;
         samp_tot_ff  <= '0;
         acc_tot_ff   <= '0;
         hvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cp_ff        <= cp_in;
         step_ff      <= step_in;
         interval_ff  <= interval_in;
         warmup_ff    <= warmup_in;
         init_ff      <= init_in;
         pos_a_ff     <= pos_a_in;
         pos_b_ff     <= pos_b_in;
         step_cnt_ff  <= step_cnt_in;
         samp_tot_ff  <= samp_tot_in;
         acc_tot_ff   <= acc_tot_in;
         hvalid_ff    <= hvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      npos_ff     <= npos_in;
      move_ok_ff  <= move_ok_in;
      acc_ff      <= acc_in;
      smp_ff      <= smp_in;
      sbin_ff     <= sbin_in;
      bcount_ff   <= bcount_in;
      rsp_data_ff <= rsp_data_in;
   end

   cpms_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .busy  (mul_busy),
      .prod  (mul_prod)
   );

   // partner position: constraint_product / new position
   cpms_div u_qdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (qdiv_start),
      .dividend ({cp_ff, {FRAC_BITS{1'b0}}}),
      .divisor  (npos_ff),
      .busy     (qdiv_busy),
      .quot     (qdiv_quot),
      .rem      ()
   );

   // step index modulo sample interval
   cpms_div u_mdiv (
      .clock    (clock),
      .reset    (reset),
      .start    (mdiv_start),
      .dividend (DIV_NUM_W'(step_cnt_ff)),
      .divisor  (DIV_DEN_W'(interval_eff)),
      .busy     (mdiv_busy),
      .quot     (),
      .rem      (mdiv_rem)
   );

   cpms_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (NUM_BINS)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

### rtl/core/cpms_ram.sv
module cpms_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 128,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/cpms_mul.sv
module cpms_mul import cpms_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MUL_W-1:0]  a,
   input  logic [MUL_W-1:0]  b,
   output logic              busy,
   output logic [PROD_W-1:0] prod
);

   logic                 busy_ff;
   logic                 busy_in;
   logic [MUL_CNT_W-1:0] cnt_ff;
   logic [MUL_CNT_W-1:0] cnt_in;
   logic [MUL_W-1:0]     a_ff;
   logic [MUL_W-1:0]     a_in;
   logic [PROD_W-1:0]    acc_ff;
   logic [PROD_W-1:0]    acc_in;
   logic [MUL_W:0]       sum;

   // Shift-add: multiplier bits leave at the bottom, partial sum enters at the top
   always_comb begin
      sum     = {1'b0, acc_ff[PROD_W-1:MUL_W]} + (acc_ff[0] ? {1'b0, a_ff} : '0);
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      acc_in  = acc_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         acc_in  = {{MUL_W{1'b0}}, b};
      end else if (busy_ff) begin
         acc_in = {sum, acc_ff[MUL_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(MUL_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      acc_ff <= acc_in;
   end

   assign busy = busy_ff;
   assign prod = acc_ff;

endmodule

### rtl/core/cpms_div.sv
module cpms_div import cpms_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] dividend,
   input  logic [DIV_DEN_W-1:0] divisor,
   output logic                 busy,
   output logic [DIV_NUM_W-1:0] quot,
   output logic [DIV_DEN_W-1:0] rem
);

   logic                 busy_ff;
   logic                 busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_CNT_W-1:0] cnt_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_DEN_W-1:0] den_in;
   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_DEN_W-1:0] rem_in;
   logic [DIV_NUM_W-1:0] q_ff;
   logic [DIV_NUM_W-1:0] q_in;
   logic [DIV_DEN_W:0]   shifted;
   logic [DIV_DEN_W:0]   trial;

   // Restoring division: dividend bits shift out of q, quotient bits shift in
   always_comb begin
      shifted = {rem_ff, q_ff[DIV_NUM_W-1]};
      trial   = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         den_in  = divisor;
         rem_in  = '0;
         q_in    = dividend;
      end else if (busy_ff) begin
         // top bit of trial set: borrow, keep the shifted remainder
         rem_in = trial[DIV_DEN_W] ? shifted[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         q_in   = {q_ff[DIV_NUM_W-2:0], ~trial[DIV_DEN_W]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign busy = busy_ff;
   assign quot = q_ff;
   assign rem  = rem_ff;

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import cpms_pkg::*;

   // Command and register codes that the package leaves unnamed
   localparam logic [1:0]           CMD_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 3'd7;

   // Tracks the sampler's chain, histogram and counters; predicts each reply
   class pair_chain_scoreboard;
      logic [POS_W-1:0]   product_reg;
      logic [POS_W-1:0]   stride_reg;
      logic [15:0]        interval_reg;
      logic [19:0]        warmup_reg;
      logic [POS_W-1:0]   start_pos_reg;

      logic [POS_W-1:0]   first_pos;
      logic [POS_W-1:0]   second_pos;
      logic [COUNT_W-1:0] steps_done;
      logic [COUNT_W-1:0] bin_counts [NUM_BINS];
      logic [COUNT_W-1:0] samples_taken;
      logic [COUNT_W-1:0] moves_accepted;

      rsp_type predicted_replies [$];
      int failures;
      int commands_seen;
      int steps_seen;
      int accepted_seen;
      int sampled_seen;

      function new();
         product_reg    = RST_CONSTRAINT_PRODUCT;
         stride_reg     = RST_STEP_SIZE;
         interval_reg   = RST_SAMPLE_INTERVAL;
         warmup_reg     = RST_WARMUP_STEPS;
         start_pos_reg  = RST_INITIAL_POSITION;
         first_pos      = RST_INITIAL_POSITION;
         second_pos     = RST_INITIAL_POSITION;
         steps_done     = '0;
         samples_taken  = '0;
         moves_accepted = '0;
         foreach (bin_counts[i]) bin_counts[i] = '0;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_CONSTRAINT_PRODUCT: product_reg   = data[POS_W-1:0];
            CSR_STEP_SIZE:          stride_reg    = data[POS_W-1:0];
            CSR_SAMPLE_INTERVAL:    interval_reg  = data[15:0];
            CSR_WARMUP_STEPS:       warmup_reg    = data;
            CSR_INITIAL_POSITION:   start_pos_reg = data[POS_W-1:0];
            default: ;
         endcase
      endfunction

      // One Metropolis step, bin read or restart applied to the tracked state
      function rsp_type predict_reply(req_type r);
         rsp_type     rsp;
         longint      old_v, prod, offset, trial, partner, binned, bin;
         logic [15:0] interval;
         rsp = '0;
         case (r.command)
            CMD_STEP: begin
               steps_seen++;
               old_v = r.pick ? longint'(second_pos) : longint'(first_pos);
               prod  = (longint'(r.disp_draw) * 2 - 65536) * longint'(stride_reg);
               // displacement rounds towards minus infinity
               if (prod >= 0) offset = prod >>> 16;
               else offset = -((-prod + 65535) >>> 16);
               trial = old_v + offset;
               if (trial > 0 && trial <= ONE_FX) begin
                  partner = (longint'(product_reg) << FRAC_BITS) / trial;
                  if (partner <= ONE_FX &&
                      longint'(r.accept_draw) * trial < (old_v << 16)) begin
                     rsp.accepted = 1'b1;
                     accepted_seen++;
                     if (r.pick) begin
                        second_pos = trial[POS_W-1:0];
                        first_pos  = partner[POS_W-1:0];
                     end else begin
                        first_pos  = trial[POS_W-1:0];
                        second_pos = partner[POS_W-1:0];
                     end
                     moves_accepted = moves_accepted + 1'b1;
                  end
               end
               // histogram sample of the picked particle, top bin saturated
               interval = (interval_reg == 16'd0) ? 16'd1 : interval_reg;
               if (steps_done % interval == 0 && steps_done > warmup_reg) begin
                  binned = r.pick ? longint'(second_pos) : longint'(first_pos);
                  bin = (binned * NUM_BINS) >> FRAC_BITS;
                  if (bin > NUM_BINS - 1) bin = NUM_BINS - 1;
                  bin_counts[bin] = bin_counts[bin] + 1'b1;
                  samples_taken   = samples_taken + 1'b1;
                  rsp.sampled     = 1'b1;
                  rsp.sampled_bin = bin[BIN_W-1:0];
                  sampled_seen++;
               end
               steps_done = steps_done + 1'b1;
            end
            CMD_READ: rsp.bin_count = bin_counts[r.read_bin];
            CMD_RESTART: begin
               first_pos      = start_pos_reg;
               second_pos     = start_pos_reg;
               steps_done     = '0;
               samples_taken  = '0;
               moves_accepted = '0;
               foreach (bin_counts[i]) bin_counts[i] = '0;
            end
            default: ;
         endcase
         rsp.position_first  = first_pos;
         rsp.position_second = second_pos;
         rsp.total_samples   = samples_taken;
         rsp.accepted_total  = moves_accepted;
         return rsp;
      endfunction

      function void note_command(req_type r);
         commands_seen++;
         predicted_replies.push_back(predict_reply(r));
      endfunction

      function string describe(rsp_type x);
         return $sformatf("acc=%0d first=%0d second=%0d smp=%0d bin=%0d count=%0d samples=%0d accepts=%0d",
                          x.accepted, x.position_first, x.position_second, x.sampled,
                          x.sampled_bin, x.bin_count, x.total_samples, x.accepted_total);
      endfunction

      function void check_reply(rsp_type got);
         rsp_type want;
         if (predicted_replies.size() == 0) begin
            failures++;
            if (failures <= 10) $display("result beat with no command outstanding: %s", describe(got));
            return;
         end
         want = predicted_replies.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= 10) begin
               $display("mismatch on reply %0d", commands_seen - predicted_replies.size());
               $display("   expected %s", describe(want));
               $display("   actual   %s", describe(got));
            end
         end
      endfunction

      function int pending();
         return predicted_replies.size();
      endfunction
   endclass

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  start     = 1'b0;
   logic                  busy;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pair_chain_scoreboard tracker = new();
   bit steady = 1'b0;
   int settings_used = 1;

   constrained_pair_metropolis_sampler_top DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Monitor: results first, then the command and register beats of this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tracker.check_reply(rsp_data);
         if (start && !busy) tracker.note_command(req_data);
         if (csr_valid && csr_ready) tracker.write_register(csr_index, csr_wdata);
      end
   end

   // Mostly short gaps, now and then a long one, none inside a steady stretch
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (steady || roll < 50) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(16, 80);
   endfunction

   function automatic req_type make_command(logic [1:0] cmd, logic pick, logic [15:0] disp,
                                            logic [15:0] draw, logic [6:0] bin);
      req_type r;
      r.command     = cmd;
      r.pick        = pick;
      r.disp_draw   = disp;
      r.accept_draw = draw;
      r.read_bin    = bin;
      return r;
   endfunction

   function automatic req_type random_command();
      req_type r;
      int roll;
      r = make_command(CMD_STEP, 1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)));
      roll = $urandom_range(0, 199);
      if (roll < 2) r.command = CMD_RESTART;
      else if (roll < 4) r.command = CMD_UNUSED;
      else if (roll < 24) r.command = CMD_READ;
      // occasional extreme draws: full swing either way, no move, sure and unlikely accept
      case ($urandom_range(0, 15))
         0: r.disp_draw = 16'd0;
         1: r.disp_draw = 16'hFFFF;
         2: r.disp_draw = 16'h8000;
         3: r.accept_draw = 16'd0;
         4: r.accept_draw = 16'hFFFF;
         default: ;
      endcase
      return r;
   endfunction

   // Command beat: optional gap, then hold start until the block takes it
   task automatic send_command(input req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
   endtask

   // wait on the clock first, so the monitor has logged the command just taken
   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      repeat ($urandom_range(0, 2)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [POS_W-1:0] product, input logic [POS_W-1:0] stride,
                                 input logic [15:0] interval, input logic [19:0] warmup,
                                 input logic [POS_W-1:0] start_pos);
      wait_idle();
      write_csr(CSR_CONSTRAINT_PRODUCT, CSR_DATA_W'(product));
      write_csr(CSR_STEP_SIZE, CSR_DATA_W'(stride));
      write_csr(CSR_SAMPLE_INTERVAL, CSR_DATA_W'(interval));
      write_csr(CSR_WARMUP_STEPS, warmup);
      write_csr(CSR_INITIAL_POSITION, CSR_DATA_W'(start_pos));
      settings_used++;
   endtask

   initial begin
      logic [POS_W-1:0] product;
      logic [POS_W-1:0] stride;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: swing extremes, no move, reads, unused command, restart
      send_command(make_command(CMD_STEP, 1'b0, 16'd0, 16'd0, 7'd0));
      send_command(make_command(CMD_STEP, 1'b1, 16'hFFFF, 16'hFFFF, 7'd0));
      send_command(make_command(CMD_STEP, 1'b0, 16'h8000, 16'd12345, 7'd0));
      send_command(make_command(CMD_READ, 1'b0, 16'd0, 16'd0, 7'd0));
      send_command(make_command(CMD_READ, 1'b0, 16'd0, 16'd0, 7'd127));
      send_command(make_command(CMD_UNUSED, 1'b1, 16'hFFFF, 16'hFFFF, 7'd127));
      send_command(make_command(CMD_RESTART, 1'b0, 16'd0, 16'd0, 7'd0));

      // Low extremes: zero product, move past one, top bin, zero interval
      apply_settings(17'd0, 17'd65536, 16'd0, 20'd0, 17'd65536);
      send_command(make_command(CMD_RESTART, 1'b0, 16'd0, 16'd0, 7'd0));
      send_command(make_command(CMD_STEP, 1'b0, 16'd0, 16'd0, 7'd0));
      send_command(make_command(CMD_STEP, 1'b0, 16'hFFFF, 16'd0, 7'd0));
      send_command(make_command(CMD_STEP, 1'b0, 16'h8000, 16'hFFFF, 7'd0));
      send_command(make_command(CMD_STEP, 1'b1, 16'h8000, 16'd0, 7'd0));
      send_command(make_command(CMD_STEP, 1'b1, 16'd40000, 16'd0, 7'd0));
      send_command(make_command(CMD_READ, 1'b0, 16'd0, 16'd0, 7'd127));
      send_command(make_command(CMD_READ, 1'b0, 16'd0, 16'd0, 7'd0));

      // High extremes: no displacement from a zero start, no sampling at all
      apply_settings(17'd65536, 17'd0, 16'd65535, 20'hFFFFF, 17'd0);
      send_command(make_command(CMD_RESTART, 1'b1, 16'hFFFF, 16'hFFFF, 7'd127));
      send_command(make_command(CMD_STEP, 1'b0, 16'd12345, 16'd0, 7'd0));
      send_command(make_command(CMD_STEP, 1'b1, 16'hFFFF, 16'hFFFF, 7'd0));
      send_command(make_command(CMD_READ, 1'b0, 16'd0, 16'd0, 7'd5));

      // Partner forced above one; a write to an unused index must change nothing
      apply_settings(17'd65536, 17'd3277, 16'd1, 20'd0, 17'd32768);
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 20'hFFFFF)));
      send_command(make_command(CMD_RESTART, 1'b0, 16'd0, 16'd0, 7'd0));
      send_command(make_command(CMD_STEP, 1'b0, 16'hFFFF, 16'd0, 7'd0));
      send_command(make_command(CMD_STEP, 1'b1, 16'd0, 16'd0, 7'd0));

      // Random phases, each under its own register setting
      for (int phase = 0; phase < 6; phase++) begin
         product = 17'($urandom_range(200, 30000));
         stride  = (phase == 3) ? 17'd65536 : 17'($urandom_range(100, 20000));
         apply_settings(product, stride, 16'($urandom_range(1, 12)),
                        20'($urandom_range(0, 150)), 17'($urandom_range(0, 65536)));
         if ($urandom_range(0, 1))
            send_command(make_command(CMD_RESTART, 1'($urandom_range(0, 1)),
                                      16'($urandom_range(0, 65535)),
                                      16'($urandom_range(0, 65535)),
                                      7'($urandom_range(0, 127))));
         for (int n = 0; n < 300; n++) begin
            if (n % 100 == 0) steady = ($urandom_range(0, 3) == 0);
            send_command(random_command());
         end
      end

      // Drain, then give the block time to show any stray beat
      wait_idle();
      repeat (60) @(posedge clock);
      $display("Ran %0d commands: %0d steps, %0d accepted moves, %0d histogram samples",
               tracker.commands_seen, tracker.steps_seen, tracker.accepted_seen,
               tracker.sampled_seen);
      $display("Register settings used: %0d; failures: %0d", settings_used, tracker.failures);
      if (tracker.failures == 0) begin
         $display("[constrained_pair_metropolis_sampler_top] OK");
      end else begin
         $display("[constrained_pair_metropolis_sampler_top] ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #12_000_000;
      $display("Timed out with %0d replies outstanding", tracker.pending());
      $display("[constrained_pair_metropolis_sampler_top] ERROR");
      $finish;
   end

endmodule
